// File: design/ark_pkg.sv
`timescale 1ns / 1ps

package ark_pkg;

  // Store geometry
  localparam int BLOCK_SIZE = 128;
  localparam int NUM_BLOCKS = 128;
  localparam int DEPTH      = BLOCK_SIZE * NUM_BLOCKS;
  localparam int OFS_W      = $clog2(BLOCK_SIZE);
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SLOT_W     = BLK_W + OFS_W;
  localparam int PTR_W      = SLOT_W + 1;
  localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
  localparam int CTR_W      = ((BLK_W > OFS_W) ? BLK_W : OFS_W) + 1;

  // Item fields
  localparam int VAL_W  = 32;
  localparam int RANK_W = 15;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_NONE     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_APP_CNT,
    S_BLK_SCAN,
    S_SLOT_SCAN,
    S_REMOVE,
    S_FINISH
  } state_e;

  // Control of the shared running-count unit
  typedef struct packed {
    logic             clear;
    logic             step;
    logic [CNT_W-1:0] inc;
  } tally_ctrl_t;

  // Write request into the slot store
  typedef struct packed {
    logic                    val_we;
    logic                    live_we;
    logic [SLOT_W-1:0]       addr;
    logic signed [VAL_W-1:0] val;
    logic                    live;
  } slot_wr_t;

endpackage

// File: design/ark_slot_ram.sv
`timescale 1ns / 1ps

module ark_slot_ram (
  input  logic                             clk_i,
  input  ark_pkg::slot_wr_t                wr_i,
  input  logic [ark_pkg::SLOT_W-1:0]       rd_addr_i,
  output logic signed [ark_pkg::VAL_W-1:0] rd_val_o,
  output logic                             rd_live_o
);
  import ark_pkg::*;

  logic signed [VAL_W-1:0] val_mem [DEPTH];
  logic                    live_mem [DEPTH];

  // Write values and live bits on separate enables
  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      val_mem[wr_i.addr] <= wr_i.val;
    end
    if (wr_i.live_we) begin
      live_mem[wr_i.addr] <= wr_i.live;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_val_o  <= val_mem[rd_addr_i];
    rd_live_o <= live_mem[rd_addr_i];
  end

endmodule

// File: design/ark_count_ram.sv
`timescale 1ns / 1ps

module ark_count_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ark_pkg::BLK_W-1:0] waddr_i,
  input  logic [ark_pkg::CNT_W-1:0] wdata_i,
  input  logic [ark_pkg::BLK_W-1:0] raddr_i,
  output logic [ark_pkg::CNT_W-1:0] rdata_o
);
  import ark_pkg::*;

  logic [CNT_W-1:0] cnt_mem [NUM_BLOCKS];

  // Write one block count
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cnt_mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= cnt_mem[raddr_i];
  end

endmodule

// File: design/ark_tally.sv
`timescale 1ns / 1ps

module ark_tally (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ark_pkg::tally_ctrl_t       ctrl_i,
  input  logic [ark_pkg::RANK_W-1:0] rank_i,
  output logic                       hit_o
);
  import ark_pkg::*;

  logic [RANK_W-1:0] seen_q, seen_d;
  logic [RANK_W:0]   sum;

  // Add the increment to the live elements passed so far, compare to rank
  assign sum   = {1'b0, seen_q} + (RANK_W + 1)'(ctrl_i.inc);
  assign hit_o = (sum >= {1'b0, rank_i});

  // Advance the running count only while the rank is not yet reached
  always_comb begin
    seen_d = seen_q;
    if (ctrl_i.clear) begin
      seen_d = '0;
    end else if (ctrl_i.step && !hit_o) begin
      seen_d = sum[RANK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

// File: design/append_and_remove_kth_store_unit.sv
`timescale 1ns / 1ps
// Append: writes the slot, then updates its block count, then presents the result.
// Remove: a block count scan, then a slot scan within the hit block, one count-memory or
// slot-memory read per cycle, then a write-back of the live bit and block count, then
// the result is presented; one item at a time.
// Reset clears control state and the write pointer only; live bits and block counts at
// or beyond the write pointer are masked, so no clearing pass is needed.
module append_and_remove_kth_store_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic signed [ark_pkg::VAL_W-1:0] value_i,
  input  logic [ark_pkg::RANK_W-1:0]       rank_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic signed [ark_pkg::VAL_W-1:0] removed_value_o
);
  import ark_pkg::*;

  state_e state_q, state_d;

  logic                    mode_q, mode_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic [RANK_W-1:0]       rank_q, rank_d;
  logic [PTR_W-1:0]        wp_q, wp_d;
  logic [CTR_W-1:0]        idx_q, idx_d;
  logic [CTR_W-1:0]        eval_q, eval_d;
  logic                    pipe_v_q, pipe_v_d;
  logic [BLK_W-1:0]        blk_q, blk_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  status_e                 res_status_q, res_status_d;
  logic signed [VAL_W-1:0] res_value_q, res_value_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;

  tally_ctrl_t             tally;
  logic                    hit;
  slot_wr_t                slot_wr;
  logic [SLOT_W-1:0]       slot_rd_addr;
  logic signed [VAL_W-1:0] slot_val_rd;
  logic                    slot_live_rd;
  logic                    cnt_we;
  logic [BLK_W-1:0]        cnt_waddr;
  logic [CNT_W-1:0]        cnt_wdata;
  logic [BLK_W-1:0]        cnt_raddr;
  logic [CNT_W-1:0]        cnt_rdata;

  logic              wp_full;
  logic [BLK_W-1:0]  wp_blk;
  logic [OFS_W-1:0]  wp_ofs;
  logic              out_free;
  logic              blk_used;
  logic [SLOT_W-1:0] eval_slot;
  logic              slot_live;
  logic              blk_last;
  logic              slot_last;

  assign wp_full   = (wp_q == PTR_W'(DEPTH));
  assign wp_blk    = wp_q[SLOT_W-1:OFS_W];
  assign wp_ofs    = wp_q[OFS_W-1:0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign blk_used  = ({1'b0, eval_q[BLK_W-1:0], {OFS_W{1'b0}}} < wp_q);
  assign eval_slot = {blk_q, eval_q[OFS_W-1:0]};
  assign slot_live = slot_live_rd && ({1'b0, eval_slot} < wp_q);
  assign blk_last  = (eval_q == CTR_W'(NUM_BLOCKS - 1));
  assign slot_last = (eval_q == CTR_W'(BLOCK_SIZE - 1));

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = out_value_q;

  ark_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .wr_i      (slot_wr),
    .rd_addr_i (slot_rd_addr),
    .rd_val_o  (slot_val_rd),
    .rd_live_o (slot_live_rd)
  );

  ark_count_ram u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  ark_tally u_tally (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tally),
    .rank_i (rank_q),
    .hit_o  (hit)
  );

  // Sequence the item through append or the two scans
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_APPEND) begin
            state_d = S_APPEND;
          end else if (rank_i == '0) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_BLK_SCAN;
          end
        end
      end
      S_APPEND: begin
        state_d = wp_full ? S_FINISH : S_APP_CNT;
      end
      S_APP_CNT: begin
        state_d = S_FINISH;
      end
      S_BLK_SCAN: begin
        if (pipe_v_q) begin
          if (hit) begin
            state_d = S_SLOT_SCAN;
          end else if (blk_last) begin
            state_d = S_FINISH;
          end
        end
      end
      S_SLOT_SCAN: begin
        if (pipe_v_q) begin
          if (hit) begin
            state_d = S_REMOVE;
          end else if (slot_last) begin
            state_d = S_FINISH;
          end
        end
      end
      S_REMOVE: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Drive memories, the shared tally and the datapath registers
  always_comb begin
    mode_d       = mode_q;
    value_d      = value_q;
    rank_d       = rank_q;
    wp_d         = wp_q;
    idx_d        = idx_q;
    eval_d       = eval_q;
    pipe_v_d     = pipe_v_q;
    blk_d        = blk_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    out_value_d  = out_value_q;

    tally        = '0;
    slot_wr      = '0;
    slot_rd_addr = {blk_q, idx_q[OFS_W-1:0]};
    cnt_we       = 1'b0;
    cnt_waddr    = blk_q;
    cnt_wdata    = '0;
    cnt_raddr    = wp_blk;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d      = mode_i;
          value_d     = value_i;
          rank_d      = rank_i;
          idx_d       = '0;
          pipe_v_d    = 1'b0;
          tally.clear = 1'b1;
          if (mode_i == MODE_REMOVE && rank_i == '0) begin
            res_status_d = ST_NONE;
            res_value_d  = '0;
          end
        end
      end
      S_APPEND: begin
        if (wp_full) begin
          res_status_d = ST_FULL;
          res_value_d  = '0;
        end else begin
          // Write the slot; the block count read is in flight
          slot_wr.val_we  = 1'b1;
          slot_wr.live_we = 1'b1;
          slot_wr.addr    = wp_q[SLOT_W-1:0];
          slot_wr.val     = value_q;
          slot_wr.live    = 1'b1;
        end
      end
      S_APP_CNT: begin
        // First slot of a block starts its count fresh
        cnt_we       = 1'b1;
        cnt_waddr    = wp_blk;
        cnt_wdata    = (wp_ofs == '0) ? CNT_W'(1) : cnt_rdata + CNT_W'(1);
        wp_d         = wp_q + PTR_W'(1);
        res_status_d = ST_APPENDED;
        res_value_d  = '0;
      end
      S_BLK_SCAN: begin
        cnt_raddr = idx_q[BLK_W-1:0];
        pipe_v_d  = (idx_q < CTR_W'(NUM_BLOCKS));
        idx_d     = pipe_v_d ? idx_q + CTR_W'(1) : idx_q;
        eval_d    = idx_q;
        if (pipe_v_q) begin
          tally.step = 1'b1;
          tally.inc  = blk_used ? cnt_rdata : '0;
          if (hit) begin
            blk_d    = eval_q[BLK_W-1:0];
            cnt_d    = tally.inc;
            idx_d    = '0;
            pipe_v_d = 1'b0;
          end else if (blk_last) begin
            res_status_d = ST_NONE;
            res_value_d  = '0;
          end
        end
      end
      S_SLOT_SCAN: begin
        pipe_v_d = (idx_q < CTR_W'(BLOCK_SIZE));
        idx_d    = pipe_v_d ? idx_q + CTR_W'(1) : idx_q;
        eval_d   = idx_q;
        if (pipe_v_q) begin
          tally.step = 1'b1;
          tally.inc  = CNT_W'(slot_live);
          if (hit) begin
            slot_d       = eval_slot;
            res_status_d = ST_REMOVED;
            res_value_d  = slot_val_rd;
          end else if (slot_last) begin
            res_status_d = ST_NONE;
            res_value_d  = '0;
          end
        end
      end
      S_REMOVE: begin
        // Drop the element and decrement its block count
        slot_wr.live_we = 1'b1;
        slot_wr.addr    = slot_q;
        slot_wr.live    = 1'b0;
        cnt_we          = 1'b1;
        cnt_waddr       = blk_q;
        cnt_wdata       = cnt_q - CNT_W'(cnt_q != '0);
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          out_value_d = res_value_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      pipe_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      pipe_v_q    <= pipe_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    value_q      <= value_d;
    rank_q       <= rank_d;
    idx_q        <= idx_d;
    eval_q       <= eval_d;
    blk_q        <= blk_d;
    cnt_q        <= cnt_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    status_q     <= status_d;
    out_value_q  <= out_value_d;
  end

  // Write pointer never passes the store depth
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PTR_W'(DEPTH))
    else $error("write pointer beyond store depth");

  // Write pointer moves only when an append updates its block count
  a_wp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APP_CNT) |=> $stable(wp_q))
    else $error("write pointer moved outside append");

  // A block count never exceeds the block size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (cnt_wdata <= CNT_W'(BLOCK_SIZE)))
    else $error("block count overflow");

  // The slot scan only stops on a live element
  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLOT_SCAN && pipe_v_q && hit) |-> slot_live)
    else $error("remove selected a dead slot");

  // A removal always follows a found element
  a_remove_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REMOVE) |-> (res_status_q == ST_REMOVED))
    else $error("remove without found element");

endmodule
